### rtl/dae_pkg.sv
package dae_pkg;

	localparam int VALUE_W     = 32;
	localparam int NUM_DIGITS  = 10;
	localparam int IDX_W       = $clog2(NUM_DIGITS);
	localparam int CHAR_W      = 6;
	localparam int BITS_PER_CY = 4;
	localparam int STEP_CNT_W  = $clog2(VALUE_W / BITS_PER_CY);
	localparam int TDATA_W     = ((CHAR_W + 7) / 8) * 8;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
	localparam logic [3:0]        DABBLE_MIN = 4'd5;
	localparam logic [3:0]        DABBLE_ADD = 4'd3;

	typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_FIND = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic find;
		logic advance;
	} dae_cmd_t;

	typedef struct packed {
		logic conv_done;
		logic last;
	} dae_stat_t;

endpackage

### rtl/dae_datapath.sv
module dae_datapath
	import dae_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dae_cmd_t            cmd,
	input  logic [VALUE_W-1:0]  value,
	output dae_stat_t           stat,
	output logic [CHAR_W-1:0]   digit_char,
	output logic                last_digit
);

	logic [VALUE_W-1:0]    bin_q;
	bcd_t                  bcd_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic [IDX_W-1:0]      idx_q;

	bcd_t               bcd_nx;
	logic [VALUE_W-1:0] bin_nx;
	logic [IDX_W-1:0]   lead;

	// shift-and-add-3, BITS_PER_CY binary bits folded in per cycle
	always_comb begin
		bcd_nx = bcd_q;
		bin_nx = bin_q;
		for (int s = 0; s < BITS_PER_CY; s++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (bcd_nx[d] >= DABBLE_MIN) begin
					bcd_nx[d] = bcd_nx[d] + DABBLE_ADD;
				end
			end
			// top bit of the digit vector falls off; it is always zero here
			bcd_nx = (4*NUM_DIGITS)'({bcd_nx, bin_nx[VALUE_W-1]});
			bin_nx = {bin_nx[VALUE_W-2:0], 1'b0};
		end
	end

	// most significant nonzero digit; zero value points at digit 0
	always_comb begin
		lead = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i] != 4'd0) begin
				lead = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cmd.step) begin
			bin_q <= bin_nx;
			bcd_q <= bcd_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.find) begin
				idx_q <= lead;
			end else if (cmd.advance) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	assign stat.conv_done = (step_q == '1);
	assign stat.last      = (idx_q == '0);

	assign digit_char = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, bcd_q[idx_q]};
	assign last_digit = stat.last;

endmodule

### rtl/dae_ctrl.sv
module dae_ctrl
	import dae_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dae_stat_t stat,
	output dae_cmd_t  cmd
);

	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx    = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				if (stat.conv_done) begin
					state_nx = ST_FIND;
				end
			end
			ST_FIND: begin
				cmd.find = 1'b1;
				state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.last) begin
						state_nx = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

### rtl/decimal_ascii_emitter_top.sv
// Conversion runs shift-and-add-3 in ST_CONV (4 bits per cycle), then ST_FIND picks the
// leading digit; ST_EMIT then sends digits, one per cycle while m_tready is high.
// A new value is accepted only in idle, after the last digit of the previous one is taken.
// Reset (arst_n low, asynchronous) returns the controller to idle; payload is not cleared.
module decimal_ascii_emitter_top
	import dae_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [5:0] digit_char, [7:6] zero
	output logic               m_tlast    // last_digit
);

	dae_cmd_t          cmd;
	dae_stat_t         stat;
	logic [CHAR_W-1:0] digit_char;

	dae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dae_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (s_tdata),
		.stat       (stat),
		.digit_char (digit_char),
		.last_digit (m_tlast)
	);

	assign m_tdata = {{(TDATA_W-CHAR_W){1'b0}}, digit_char};

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a digit is pending");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] <= 6'd57) && (m_tdata[5:0] >= 6'd48))
		else $error("digit out of ASCII range");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("not idle after last digit");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("digit run broken before last digit");
`endif

endmodule
